// ===== rtl/grid_point_to_cell_lookup_top_assert.svh =====
// ---------------------------------------------------------------------------
// Grid lookup assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef GRID_POINT_TO_CELL_LOOKUP_TOP_ASSERT_SVH
`define GRID_POINT_TO_CELL_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define GPCL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grid lookup assertion failed");
// Next-cycle implication
`define GPCL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grid lookup assertion failed");
`else
`define GPCL_ASSERT_IMP(label, clk, rstn, ante, cons)
`define GPCL_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/gpcl_pkg.sv =====
// ---------------------------------------------------------------------------
// Grid lookup package
// Register indexes, field types and small helpers for the grid lookup.
// ---------------------------------------------------------------------------
`default_nettype none
package gpcl_pkg;

    localparam int unsigned MAX_POINTS     = 1024;
    localparam int unsigned NUM_AXES       = 3;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned PTS_FIELD_W    = 10;
    localparam int unsigned NPTS_W         = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_PTS   = 3'd6;

    localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;

    typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic signed [31:0]           q16_t;
    typedef logic        [31:0]           uq16_t;
    typedef logic        [29:0]           pts_packed_t;
    typedef logic        [29:0]           index_t;
    typedef logic        [9:0]            cell_t;
    typedef logic        [NPTS_W-1:0]     npts_t;

    // Saturate the point count of one axis to MAX_POINTS
    function automatic npts_t clamp_points(input logic [PTS_FIELD_W-1:0] raw);
        npts_t lim;
        lim = NPTS_W'(MAX_POINTS);
        clamp_points = ({1'b0, raw} > lim) ? lim : {1'b0, raw};
    endfunction

    // Saturate a wide signed offset to signed 32 bits
    function automatic q16_t sat_q16(input logic signed [49:0] v);
        if (v[49:31] == {19{1'b0}} || v[49:31] == {19{1'b1}}) begin
            sat_q16 = v[31:0];
        end else if (v[49]) begin
            sat_q16 = 32'sh8000_0000;
        end else begin
            sat_q16 = 32'sh7FFF_FFFF;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/grid_point_to_cell_lookup_top.sv =====
// ---------------------------------------------------------------------------
// Uniform 3D grid cell lookup
// Maps a signed Q16.16 point to its grid cell, cell index and cell offsets.
// ---------------------------------------------------------------------------
// Usage:
//   Configure origin, reciprocal steps and point counts through cfg_we /
//   cfg_index / cfg_data while no query is in flight; writes are registered.
//   Queries enter on the s_ valid/ready channel (func selects contain or
//   nearest mode), results leave on the m_ valid/ready channel, one result
//   per query, in order.
//   An input transfer passes in order through five register stages (difference,
//   33x33 multiply, floor/clamp/saturate, index multiply, index multiply-add),
//   and m_valid rises when it reaches the last one. Throughput is one query
//   per cycle while the receiver holds m_ready high; each stage takes one item
//   per cycle unless it is full and its successor does not load.
//   Every stage has its own valid bit and loads when it is empty or its
//   successor loads, so bubbles close up when the receiver stalls; with
//   m_ready low the pipeline fills and then holds five items and s_ready
//   drops. Nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   registers: origins 0, reciprocal steps 1.0, point counts 0 (so every
//   query reports not found until the counts are written).
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_point_to_cell_lookup_top_assert.svh"
module grid_point_to_cell_lookup_top (
    input  wire                      aclk,
    input  wire                      aresetn,
    // configuration writes
    input  wire                      cfg_we,
    input  wire gpcl_pkg::cfg_idx_t  cfg_index,
    input  wire gpcl_pkg::cfg_data_t cfg_data,
    // query channel
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire                      s_func,
    input  wire gpcl_pkg::q16_t      s_pos_x,
    input  wire gpcl_pkg::q16_t      s_pos_y,
    input  wire gpcl_pkg::q16_t      s_pos_z,
    // result channel
    output logic                     m_valid,
    input  wire                      m_ready,
    output logic                     m_found,
    output gpcl_pkg::index_t         m_cell_index,
    output gpcl_pkg::cell_t          m_cell_x,
    output gpcl_pkg::cell_t          m_cell_y,
    output gpcl_pkg::cell_t          m_cell_z,
    output gpcl_pkg::q16_t           m_frac_x,
    output gpcl_pkg::q16_t           m_frac_y,
    output gpcl_pkg::q16_t           m_frac_z
);
    import gpcl_pkg::*;

    localparam int unsigned STAGES = 5;

    // Configuration registers
    q16_t        origin_reg   [NUM_AXES];
    uq16_t       inv_step_reg [NUM_AXES];
    pts_packed_t grid_pts_reg;

    // Pipeline control
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] valid_next;
    logic [STAGES+1:1] load;

    // Stage 1: differences
    logic                func1_reg;
    logic signed [32:0]  diff_reg [NUM_AXES];
    // Stage 2: floored grid coordinates
    logic                func2_reg;
    logic signed [48:0]  grid_reg [NUM_AXES];
    logic signed [65:0]  prod     [NUM_AXES];
    // Stage 3: cells and offsets
    logic                found3_reg;
    cell_t               cell3_reg [NUM_AXES];
    q16_t                frac3_reg [NUM_AXES];
    logic                found3_next;
    cell_t               cell3_next [NUM_AXES];
    q16_t                frac3_next [NUM_AXES];
    // Stage 4: partial index
    logic                found4_reg;
    cell_t               cell4_reg [NUM_AXES];
    q16_t                frac4_reg [NUM_AXES];
    logic [21:0]         part4_reg;
    logic [21:0]         part4_next;
    // Stage 5: output register
    logic                found5_reg;
    cell_t               cell5_reg [NUM_AXES];
    q16_t                frac5_reg [NUM_AXES];
    index_t              index5_reg;
    logic [32:0]         index5_full;

    npts_t               npts [NUM_AXES];
    npts_t               top  [NUM_AXES];
    logic                pts_ok;
    q16_t                pos  [NUM_AXES];
    logic                miss_zero;

    assign pos[0] = s_pos_x;
    assign pos[1] = s_pos_y;
    assign pos[2] = s_pos_z;

    // Decode point counts and the last cell per axis
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            npts[a] = clamp_points(grid_pts_reg[a*PTS_FIELD_W +: PTS_FIELD_W]);
            top[a]  = npts[a] - NPTS_W'(2);
        end
        pts_ok = (npts[0] >= NPTS_W'(2)) && (npts[1] >= NPTS_W'(2))
              && (npts[2] >= NPTS_W'(2));
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                origin_reg[a]   <= '0;
                inv_step_reg[a] <= INV_STEP_RESET;
            end
            grid_pts_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:   origin_reg[0]   <= cfg_data;
                REG_ORIGIN_Y:   origin_reg[1]   <= cfg_data;
                REG_ORIGIN_Z:   origin_reg[2]   <= cfg_data;
                REG_INV_STEP_X: inv_step_reg[0] <= cfg_data;
                REG_INV_STEP_Y: inv_step_reg[1] <= cfg_data;
                REG_INV_STEP_Z: inv_step_reg[2] <= cfg_data;
                REG_GRID_PTS:   grid_pts_reg    <= cfg_data[29:0];
                default: ;
            endcase
        end
    end

    // Stage load enables: a stage loads when empty or when its successor loads
    always_comb begin
        load[STAGES+1] = m_ready;
        for (int k = STAGES; k >= 1; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next = valid_reg;
        if (load[1]) begin
            valid_next[1] = s_valid;
        end
        for (int k = 2; k <= STAGES; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign s_ready = load[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: subtract the origin
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            func1_reg <= s_func;
            for (int a = 0; a < NUM_AXES; a++) begin
                diff_reg[a] <= 33'(pos[a]) - 33'(origin_reg[a]);
            end
        end
    end

    // Stage 2: scale by the reciprocal step and floor to Q16.16
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            prod[a] = diff_reg[a] * $signed({1'b0, inv_step_reg[a]});
        end
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            func2_reg <= func1_reg;
            for (int a = 0; a < NUM_AXES; a++) begin
                grid_reg[a] <= prod[a][64:16];
            end
        end
    end

    // Stage 3: floor to cells, check or clamp, take saturated offsets
    always_comb begin
        logic signed [32:0] cval;
        logic               below;
        logic               above;
        logic signed [49:0] off;
        logic               all_ok;
        logic               axis_ok [NUM_AXES];
        all_ok = pts_ok;
        for (int a = 0; a < NUM_AXES; a++) begin
            cval  = grid_reg[a][48:16];
            below = cval[32];
            above = !below && (cval[31:0] > 32'(top[a]));
            if (below) begin
                off           = 50'(grid_reg[a]);
                cell3_next[a] = '0;
            end else if (above) begin
                off           = 50'(grid_reg[a]) - $signed({23'b0, top[a], 16'b0});
                cell3_next[a] = top[a][9:0];
            end else begin
                off           = $signed({34'b0, grid_reg[a][15:0]});
                cell3_next[a] = cval[9:0];
            end
            frac3_next[a] = sat_q16(off);
            axis_ok[a]    = func2_reg || !(below || above);
            all_ok        = all_ok && axis_ok[a];
        end
        found3_next = all_ok;
        // Zero every field of a miss; the index then comes out zero too
        if (!all_ok) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                cell3_next[a] = '0;
                frac3_next[a] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            found3_reg <= found3_next;
            cell3_reg  <= cell3_next;
            frac3_reg  <= frac3_next;
        end
    end

    // Stage 4: y + (ny-1)*z
    assign part4_next = 22'(cell3_reg[1])
                      + 22'((top[1] + NPTS_W'(1)) * 21'(cell3_reg[2]));

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            found4_reg <= found3_reg;
            cell4_reg  <= cell3_reg;
            frac4_reg  <= frac3_reg;
            part4_reg  <= part4_next;
        end
    end

    // Stage 5: x + (nx-1)*partial, wrapped to the index width
    assign index5_full = 33'(cell4_reg[0])
                       + 33'((top[0] + NPTS_W'(1)) * 33'(part4_reg));

    always_ff @(posedge aclk) begin
        if (load[5]) begin
            found5_reg <= found4_reg;
            cell5_reg  <= cell4_reg;
            frac5_reg  <= frac4_reg;
            index5_reg <= index5_full[29:0];
        end
    end

    // Drive the result channel from the output register
    assign m_valid      = valid_reg[STAGES];
    assign m_found      = found5_reg;
    assign m_cell_index = index5_reg;
    assign m_cell_x     = cell5_reg[0];
    assign m_cell_y     = cell5_reg[1];
    assign m_cell_z     = cell5_reg[2];
    assign m_frac_x     = frac5_reg[0];
    assign m_frac_y     = frac5_reg[1];
    assign m_frac_z     = frac5_reg[2];

    assign miss_zero = (m_cell_index == '0) && (m_cell_x == '0) && (m_cell_y == '0)
                    && (m_cell_z == '0) && (m_frac_x == '0) && (m_frac_y == '0)
                    && (m_frac_z == '0);

    // A miss carries all-zero fields
    `GPCL_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid && !m_found, miss_zero)
    // An input transfer always lands in the first stage
    `GPCL_ASSERT_NXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, valid_reg[1])
    // A stalled result stays in the output register
    `GPCL_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    // A full pipeline under stall refuses new input
    `GPCL_ASSERT_IMP(a_full_blocks, aclk, aresetn, (valid_reg == '1) && !m_ready, !s_ready)

endmodule
`default_nettype wire

// ===== sim/tb_grid_point_to_cell_lookup_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Grid cell lookup testbench
// Drives point queries through the valid/ready input channel and checks each
// result against an in-bench prediction of the cell, index and offsets. The
// run covers directed corner points, a receiver hold-off and random queries
// under random grid settings.
// ---------------------------------------------------------------------------
module tb_grid_point_to_cell_lookup_top;
    import gpcl_pkg::*;

    localparam cfg_idx_t    REG_UNMAPPED    = 3'd7;
    localparam q16_t        Q_ONE           = 32'sh0001_0000;
    localparam int unsigned RX_HOLD_CYCLES  = 60;
    localparam int unsigned RANDOM_PHASES   = 10;
    localparam int unsigned ITEMS_PER_PHASE = 115;
    localparam logic signed [63:0] FRAC_MAX = 64'sd2147483647;
    localparam logic signed [63:0] FRAC_MIN = -64'sd2147483648;

    typedef struct packed {
        logic   found;
        index_t cell_index;
        cell_t  cell_x;
        cell_t  cell_y;
        cell_t  cell_z;
        q16_t   frac_x;
        q16_t   frac_y;
        q16_t   frac_z;
    } lookup_res_t;

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    cfg_idx_t  cfg_index = '0;
    cfg_data_t cfg_data  = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    logic      s_func    = 1'b0;
    q16_t      s_pos_x   = '0;
    q16_t      s_pos_y   = '0;
    q16_t      s_pos_z   = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    logic      m_found;
    index_t    m_cell_index;
    cell_t     m_cell_x;
    cell_t     m_cell_y;
    cell_t     m_cell_z;
    q16_t      m_frac_x;
    q16_t      m_frac_y;
    q16_t      m_frac_z;

    // Register mirror
    q16_t        org_x = '0, org_y = '0, org_z = '0;
    uq16_t       inv_x = INV_STEP_RESET, inv_y = INV_STEP_RESET, inv_z = INV_STEP_RESET;
    pts_packed_t grid_pts = '0;

    lookup_res_t lookup_expect_q[$];
    int unsigned mismatch_count = 0;
    logic        tx_gapless  = 1'b0;
    logic        rx_gapless  = 1'b0;
    logic        rx_hold_req = 1'b0;

    grid_point_to_cell_lookup_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_cell_index (m_cell_index),
        .m_cell_x     (m_cell_x),
        .m_cell_y     (m_cell_y),
        .m_cell_z     (m_cell_z),
        .m_frac_x     (m_frac_x),
        .m_frac_y     (m_frac_y),
        .m_frac_z     (m_frac_z)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Map one axis to its cell; returns 0 when outside the cells in contain mode
    function automatic logic axis_to_cell(input q16_t pos, input q16_t org, input uq16_t inv,
                                          input int unsigned npts, input logic nearest,
                                          output cell_t cell_out, output q16_t frac);
        logic signed [63:0] p64, o64, d, t, c, f, top;
        logic [63:0] mag, prod, q;
        cell_out = '0;
        frac     = '0;
        p64  = 64'(pos);
        o64  = 64'(org);
        d    = p64 - o64;
        mag  = d[63] ? 64'(-d) : 64'(d);
        prod = mag * {32'd0, inv};
        // Floor the Q32.32 product to Q16.16 toward minus infinity
        q = prod >> 16;
        if (d[63] && prod[15:0] != 16'd0) begin
            q = q + 64'd1;
        end
        t   = d[63] ? -$signed(q) : $signed(q);
        c   = t >>> 16;
        top = $signed(64'(npts)) - 64'sd2;
        if (c < 0 || c > top) begin
            if (!nearest) begin
                return 1'b0;
            end
            c = (c < 0) ? 64'sd0 : top;
        end
        f = t - (c <<< 16);
        if (f > FRAC_MAX) begin
            f = FRAC_MAX;
        end else if (f < FRAC_MIN) begin
            f = FRAC_MIN;
        end
        cell_out = c[9:0];
        frac     = f[31:0];
        return 1'b1;
    endfunction

    // Expected result of one query under the mirrored registers
    function automatic lookup_res_t predict_lookup(input logic nearest, input q16_t px,
                                                   input q16_t py, input q16_t pz);
        lookup_res_t r;
        int unsigned nx, ny, nz;
        logic        ok;
        logic [63:0] lin;
        r = '0;
        // a 10 bit count never exceeds MAX_POINTS, so no saturation here
        nx = 32'(grid_pts[9:0]);
        ny = 32'(grid_pts[19:10]);
        nz = 32'(grid_pts[29:20]);
        ok = nx >= 2 && ny >= 2 && nz >= 2;
        if (ok) ok = axis_to_cell(px, org_x, inv_x, nx, nearest, r.cell_x, r.frac_x);
        if (ok) ok = axis_to_cell(py, org_y, inv_y, ny, nearest, r.cell_y, r.frac_y);
        if (ok) ok = axis_to_cell(pz, org_z, inv_z, nz, nearest, r.cell_z, r.frac_z);
        if (!ok) begin
            return '0;
        end
        lin = 64'(r.cell_x) + 64'(nx - 1) * (64'(r.cell_y) + 64'(ny - 1) * 64'(r.cell_z));
        r.found      = 1'b1;
        r.cell_index = lin[29:0];
        return r;
    endfunction

    function automatic pts_packed_t pack_points(input int unsigned nx, input int unsigned ny,
                                                input int unsigned nz);
        return {nz[9:0], ny[9:0], nx[9:0]};
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned rand_points();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)  return $urandom_range(0, 1);
        if (r < 15) return 1023;
        if (r < 70) return $urandom_range(2, 8);
        return $urandom_range(2, 1023);
    endfunction

    function automatic q16_t rand_origin();
        if ($urandom_range(0, 9) < 6) return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        return $urandom;
    endfunction

    function automatic uq16_t rand_inv();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 32'hFFFF_FFFF;
        if (r < 30) return $urandom;
        return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endfunction

    // Coordinate mostly over the grid and a margin round it, else any value
    function automatic q16_t rand_coord(input q16_t org, input uq16_t inv,
                                        input int unsigned npts);
        logic signed [63:0] o64, span, lo, hi, v;
        logic [63:0] pick;
        if (inv == 0 || $urandom_range(0, 3) == 0) return $urandom;
        o64  = 64'(org);
        span = ((64'(npts) + 64'd1) << 32) / 64'(inv);
        if (span > 64'sh2_0000_0000) span = 64'sh2_0000_0000;
        lo   = o64 - span / 8;
        hi   = o64 + span + span / 8;
        pick = {$urandom, $urandom} % 64'(hi - lo + 1);
        v    = lo + $signed(pick);
        if (v > FRAC_MAX) v = FRAC_MAX;
        if (v < FRAC_MIN) v = FRAC_MIN;
        return v[31:0];
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // Check each result transfer, then record the expectation of each query transfer
    always @(posedge aclk) begin
        lookup_res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (lookup_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result transfer with nothing expected", $time);
                    end
                end else begin
                    want = lookup_expect_q.pop_front();
                    check_field("found", 32'(want.found), 32'(m_found));
                    check_field("cell_index", 32'(want.cell_index), 32'(m_cell_index));
                    check_field("cell_x", 32'(want.cell_x), 32'(m_cell_x));
                    check_field("cell_y", 32'(want.cell_y), 32'(m_cell_y));
                    check_field("cell_z", 32'(want.cell_z), 32'(m_cell_z));
                    check_field("frac_x", want.frac_x, m_frac_x);
                    check_field("frac_y", want.frac_y, m_frac_y);
                    check_field("frac_z", want.frac_z, m_frac_z);
                end
            end
            if (s_valid && s_ready) begin
                lookup_expect_q.push_back(predict_lookup(s_func, s_pos_x, s_pos_y, s_pos_z));
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request
    initial begin
        int unsigned n;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                n = rx_gapless ? 0 : pick_gap();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    // Offer one query and hold it until the transfer
    task automatic send_query(input logic nearest, input q16_t px, input q16_t py,
                              input q16_t pz);
        int unsigned gap;
        gap = tx_gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= nearest;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait for every expected result
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lookup_expect_q.size() != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input cfg_idx_t idx, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_ORIGIN_X:   org_x = data;
            REG_ORIGIN_Y:   org_y = data;
            REG_ORIGIN_Z:   org_z = data;
            REG_INV_STEP_X: inv_x = data;
            REG_INV_STEP_Y: inv_y = data;
            REG_INV_STEP_Z: inv_z = data;
            REG_GRID_PTS:   grid_pts = data[29:0];
            default: ;
        endcase
    endtask

    // Load a whole grid setting once the block is idle
    task automatic apply_grid(input q16_t ox, input q16_t oy, input q16_t oz,
                              input uq16_t ix, input uq16_t iy, input uq16_t iz,
                              input pts_packed_t pts);
        wait_idle();
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_ORIGIN_Z, oz);
        reg_write(REG_INV_STEP_X, ix);
        reg_write(REG_INV_STEP_Y, iy);
        reg_write(REG_INV_STEP_Z, iz);
        // top bits above the packed counts must be dropped
        reg_write(REG_GRID_PTS, {2'($urandom_range(0, 3)), pts});
        cfg_we <= 1'b0;
    endtask

    // Counts are zero out of reset, so nothing is found
    task automatic test_reset_state();
        send_query(1'b0, '0, '0, '0);
        send_query(1'b1, Q_ONE, Q_ONE, Q_ONE);
    endtask

    // A write beyond the register list changes nothing
    task automatic test_unmapped_index();
        wait_idle();
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send_query(1'b1, '0, '0, '0);
    endtask

    // Inside, on the upper edge and just below the origin, both modes
    task automatic test_contain_and_clamp();
        apply_grid('0, '0, '0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET,
                   pack_points(4, 5, 6));
        send_query(1'b0, 32'sh0001_8000, 32'sh0002_4000, 32'sh0003_C000);
        send_query(1'b0, '0, '0, '0);
        send_query(1'b0, 32'sh0003_0000, '0, '0);
        send_query(1'b1, 32'sh0003_0000, '0, '0);
        send_query(1'b0, -32'sd1, '0, '0);
        send_query(1'b1, -32'sd1, '0, '0);
        send_query(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_query(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    // Extreme origins and steps, offsets saturating both ways, zero step
    task automatic test_saturation_extremes();
        apply_grid(32'sh8000_0000, 32'sh7FFF_FFFF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0,
                   pack_points(2, 2, 2));
        send_query(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345);
        send_query(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, $urandom);
        send_query(1'b1, '0, '0, -32'sd1);
    endtask

    // Too few points on one axis, then the largest grid
    task automatic test_axis_counts();
        apply_grid('0, '0, '0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET,
                   pack_points(1023, 1, 1023));
        send_query(1'b0, Q_ONE, '0, Q_ONE);
        send_query(1'b1, Q_ONE, '0, Q_ONE);
        apply_grid('0, '0, '0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET,
                   pack_points(0, 2, 2));
        send_query(1'b1, '0, '0, '0);
        apply_grid('0, '0, '0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET,
                   pack_points(1023, 1023, 1023));
        send_query(1'b1, 32'sh03FE_8000, 32'sh07D0_0000, -32'sh0005_0000);
        send_query(1'b0, 32'sh03FD_FFFF, 32'sh0000_8000, 32'sh03FD_0000);
    endtask

    // Hold the receiver off while queries keep coming, then drain
    task automatic test_receiver_hold();
        int i;
        apply_grid(Q_ONE, -Q_ONE, 32'sh0000_4000, 32'h0002_0000, INV_STEP_RESET,
                   32'h0000_8000, pack_points(8, 8, 8));
        rx_hold_req = 1'b1;
        tx_gapless  = 1'b1;
        for (i = 0; i < 30; i++) begin
            send_query(1'($urandom_range(0, 1)), rand_coord(org_x, inv_x, 8),
                       rand_coord(org_y, inv_y, 8), rand_coord(org_z, inv_z, 8));
        end
        tx_gapless = 1'b0;
        wait_idle();
    endtask

    // Random grid settings, each with a run of random queries
    task automatic test_random_queries();
        int unsigned phase, i;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_grid(rand_origin(), rand_origin(), rand_origin(),
                       rand_inv(), rand_inv(), rand_inv(),
                       pack_points(rand_points(), rand_points(), rand_points()));
            tx_gapless = ($urandom_range(0, 3) == 0);
            rx_gapless = ($urandom_range(0, 3) == 0);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_query(1'($urandom_range(0, 1)),
                           rand_coord(org_x, inv_x, 32'(grid_pts[9:0])),
                           rand_coord(org_y, inv_y, 32'(grid_pts[19:10])),
                           rand_coord(org_z, inv_z, 32'(grid_pts[29:20])));
            end
        end
        tx_gapless = 1'b0;
        rx_gapless = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_unmapped_index();
        test_contain_and_clamp();
        test_saturation_extremes();
        test_axis_counts();
        test_receiver_hold();
        test_random_queries();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && lookup_expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
